// ----- hdl/rrqs_pkg.sv -----
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared types and constants for the round-robin quantum scheduler.
// ----------------------------------------------------------------------------
package rrqs_pkg;

    localparam int unsigned ID_W    = 4;
    localparam int unsigned SLICE_W = 8;
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned IN_W    = 8;
    localparam int unsigned OUT_W   = 24;

    localparam logic [ID_W-1:0]    FIRST_GUEST_RST = 4'd0;
    localparam logic [ID_W-1:0]    LAST_GUEST_RST  = 4'd3;
    localparam logic [SLICE_W-1:0] QUANTUM_RST     = 8'd5;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SWITCH = 2'd1,
        OP_TRAP   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [CIDX_W-1:0] {
        CFG_FIRST_GUEST   = 3'd0,
        CFG_LAST_GUEST    = 3'd1,
        CFG_QUANTUM       = 3'd2,
        CFG_MANUAL_ENABLE = 3'd3,
        CFG_MANUAL_GUEST  = 3'd4
    } t_cfg_index;

    typedef struct packed {
        t_opcode         opcode;
        logic [ID_W-1:0] target_guest;
        logic            lock_after;
    } t_item;

    typedef struct packed {
        logic [ID_W-1:0]    first_guest;
        logic [ID_W-1:0]    last_guest;
        logic [SLICE_W-1:0] quantum;
        logic               manual_enable;
        logic [ID_W-1:0]    manual_guest;
    } t_cfg;

    typedef struct packed {
        logic            locked;
        logic            pending_valid;
        logic [ID_W-1:0] pending_guest;
        logic            current_valid;
        logic [ID_W-1:0] current_guest;
        logic            previous_valid;
        logic [ID_W-1:0] previous_guest;
        logic            switched;
        logic            status;
    } t_result;

endpackage

// ----- hdl/rrqs_slice_mem.sv -----
// ----------------------------------------------------------------------------
// rrqs_slice_mem
// Per-guest slice counter RAM: one write and one registered read per cycle,
// per-entry valid bits so unwritten entries read as zero, and a bypass for a
// write landing in the same cycle as the read.
// ----------------------------------------------------------------------------
module rrqs_slice_mem
    import rrqs_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [SLICE_W-1:0] o_rd_data,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [SLICE_W-1:0] i_wr_data
);

    logic [SLICE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    logic [SLICE_W-1:0] r_q;
    logic               r_q_vld;
    logic               r_byp;
    logic [SLICE_W-1:0] r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
            r_byp   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_vld <= r_vld[i_rd_addr];
                r_byp   <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : (r_q_vld ? r_q : '0);

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> (32'(i_wr_addr) < DEPTH))
        else $error("slice write beyond depth");

endmodule

// ----- hdl/rrqs_sched_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrqs_sched_ctrl
// Execute stage: running/pending/lock registers and the per-event update,
// producing the slice counter write-back and the next read address.
// ----------------------------------------------------------------------------
module rrqs_sched_ctrl
    import rrqs_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = 16,
    parameter int unsigned AW         = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  t_item              i_item,
    input  t_cfg               i_cfg,
    input  logic [SLICE_W-1:0] i_slice,
    output t_result            o_res,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_slot,
    output logic [SLICE_W-1:0] o_wr_data,
    output logic [AW-1:0]      o_rd_slot
);

    localparam logic [6:0] GC = 7'(SLOT_COUNT);

    function automatic logic [AW-1:0] slot_of(input logic [ID_W-1:0] id);
        logic [6:0] v;
        v = {3'b000, id};
        for (int i = 0; i < 8; i++) begin
            if (v >= GC) begin
                v = v - GC;
            end
        end
        return v[AW-1:0];
    endfunction

    logic [ID_W-1:0] r_run_id, n_run_id;
    logic            r_run_ok, n_run_ok;
    logic [ID_W-1:0] r_wait_id, n_wait_id;
    logic            r_wait_ok, n_wait_ok;
    logic            r_lock, n_lock;

    logic [ID_W-1:0] nxt_id;
    logic [ID_W-1:0] wrap_id;
    logic            prev_ok;

    always_comb begin
        n_run_id  = r_run_id;
        n_run_ok  = r_run_ok;
        n_wait_id = r_wait_id;
        n_wait_ok = r_wait_ok;
        n_lock    = r_lock;
        o_wr_en   = 1'b0;
        o_wr_slot = slot_of(r_run_id);
        o_wr_data = '0;
        nxt_id    = r_run_id;
        wrap_id   = (r_run_id < i_cfg.last_guest) ? r_run_id + 4'd1 : i_cfg.first_guest;
        prev_ok   = 1'b0;
        o_res     = '0;
        o_res.status = 1'b1;

        unique case (i_item.opcode)
            OP_TICK: begin
                if (i_cfg.manual_enable) begin
                    nxt_id = i_cfg.manual_guest;
                end else if (!r_run_ok) begin
                    nxt_id = i_cfg.first_guest;
                end else if (i_slice > 8'd1) begin
                    o_wr_en   = 1'b1;
                    o_wr_data = i_slice - 8'd1;
                end else begin
                    nxt_id    = wrap_id;
                    o_wr_en   = 1'b1;
                    o_wr_data = (wrap_id == r_run_id) ? i_cfg.quantum : '0;
                end
                if (!r_lock) begin
                    n_wait_id    = nxt_id;
                    n_wait_ok    = 1'b1;
                    o_res.status = 1'b0;
                end
            end
            OP_SWITCH: begin
                if (!r_lock) begin
                    n_wait_id    = i_item.target_guest;
                    n_wait_ok    = 1'b1;
                    o_res.status = 1'b0;
                end
                if (i_item.lock_after) begin
                    n_lock = 1'b1;
                end
            end
            OP_TRAP: begin
                o_wr_slot = slot_of(r_wait_id);
                o_wr_data = i_cfg.quantum;
                if (!r_run_ok) begin
                    if (r_wait_ok) begin
                        o_wr_en      = 1'b1;
                        n_run_id     = r_wait_id;
                        n_run_ok     = 1'b1;
                        o_res.switched = 1'b1;
                        o_res.status = 1'b0;
                    end
                end else if (r_wait_ok && (r_wait_id != r_run_id)) begin
                    o_wr_en      = 1'b1;
                    prev_ok      = 1'b1;
                    n_run_id     = r_wait_id;
                    n_wait_ok    = 1'b0;
                    o_res.switched = 1'b1;
                    o_res.status = 1'b0;
                end
                n_lock = 1'b0;
            end
            default: begin
            end
        endcase

        o_res.previous_valid = prev_ok;
        o_res.previous_guest = prev_ok ? r_run_id : '0;
        o_res.current_valid  = n_run_ok;
        o_res.current_guest  = n_run_ok ? n_run_id : '0;
        o_res.pending_valid  = n_wait_ok;
        o_res.pending_guest  = n_wait_ok ? n_wait_id : '0;
        o_res.locked         = n_lock;

        if (!i_fire) begin
            o_wr_en   = 1'b0;
            n_run_id  = r_run_id;
            n_run_ok  = r_run_ok;
            n_wait_id = r_wait_id;
            n_wait_ok = r_wait_ok;
            n_lock    = r_lock;
        end
    end

    assign o_rd_slot = slot_of(n_run_id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_id  <= '0;
            r_run_ok  <= 1'b0;
            r_wait_id <= '0;
            r_wait_ok <= 1'b0;
            r_lock    <= 1'b0;
        end else begin
            r_run_id  <= n_run_id;
            r_run_ok  <= n_run_ok;
            r_wait_id <= n_wait_id;
            r_wait_ok <= n_wait_ok;
            r_lock    <= n_lock;
        end
    end

    a_run_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_ok |=> r_run_ok)
        else $error("running guest lost");

    a_switch_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.switched && o_res.previous_valid) |=> (!r_wait_ok && !r_lock))
        else $error("pending or lock left after switch");

endmodule

// ----- hdl/round_robin_quantum_scheduler_core.sv -----
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_core
// Round-robin time-slice guest scheduler for one CPU.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one event per transfer: tuser holds the opcode (timer tick,
//   switch request, trap exit), tdata the target guest and lock flag.
//   m_axis returns one result per event: status, switch info, current and
//   pending guest, lock state.
//   Configuration registers are written through i_cfg_* while no event is in
//   flight; writes to unused indexes are dropped.
// Timing:
//   When the event is taken, the slice RAM is read at the running guest's
//   slot; in the execute stage the event executes and writes the slot back,
//   and its result is registered into the output register. One event per
//   cycle while no result is held, with a bypass covering back-to-back
//   access to the same slot.
// Reset: running, pending and lock clear; all slice counters read zero.
// Stall: a held result stalls the execute stage, and s_axis_tready drops with it.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler_core
    import rrqs_pkg::*;
#(
    parameter int unsigned SLOT_COUNT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,  // target_guest[3:0], lock_after[4]
    input  logic [1:0]        s_axis_tuser,  // opcode[1:0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata   // status, switched, previous_guest,
                                             // previous_valid, current_guest,
                                             // current_valid, pending_guest,
                                             // pending_valid, locked
);

    localparam int unsigned AW = $clog2(SLOT_COUNT);

    t_cfg    r_cfg;
    t_item   r_e_item;
    logic    r_e_vld;
    logic    r_o_vld;
    t_result r_o_res;

    logic               e_fire;
    logic               s_accept;
    t_result            e_res;
    logic [SLICE_W-1:0] slice_q;
    logic               wr_en;
    logic [AW-1:0]      wr_slot;
    logic [SLICE_W-1:0] wr_data;
    logic [AW-1:0]      rd_slot;

    assign e_fire        = r_e_vld && (!r_o_vld || m_axis_tready);
    assign s_axis_tready = !r_e_vld || e_fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_guest   <= FIRST_GUEST_RST;
            r_cfg.last_guest    <= LAST_GUEST_RST;
            r_cfg.quantum       <= QUANTUM_RST;
            r_cfg.manual_enable <= 1'b0;
            r_cfg.manual_guest  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FIRST_GUEST:   r_cfg.first_guest   <= i_cfg_wdata[ID_W-1:0];
                CFG_LAST_GUEST:    r_cfg.last_guest    <= i_cfg_wdata[ID_W-1:0];
                CFG_QUANTUM:       r_cfg.quantum       <= i_cfg_wdata[SLICE_W-1:0];
                CFG_MANUAL_ENABLE: r_cfg.manual_enable <= i_cfg_wdata[0];
                CFG_MANUAL_GUEST:  r_cfg.manual_guest  <= i_cfg_wdata[ID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_e_item.opcode       <= t_opcode'(s_axis_tuser);
            r_e_item.target_guest <= s_axis_tdata[3:0];
            r_e_item.lock_after   <= s_axis_tdata[4];
        end
        if (e_fire) begin
            r_o_res <= e_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_e_vld <= s_axis_tvalid;
            end
            if (e_fire) begin
                r_o_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    rrqs_slice_mem #(
        .DEPTH (SLOT_COUNT),
        .AW    (AW)
    ) u_slice_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_accept),
        .i_rd_addr (rd_slot),
        .o_rd_data (slice_q),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_slot),
        .i_wr_data (wr_data)
    );

    rrqs_sched_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .AW         (AW)
    ) u_sched_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (e_fire),
        .i_item    (r_e_item),
        .i_cfg     (r_cfg),
        .i_slice   (slice_q),
        .o_res     (e_res),
        .o_wr_en   (wr_en),
        .o_wr_slot (wr_slot),
        .o_wr_data (wr_data),
        .o_rd_slot (rd_slot)
    );

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = {(OUT_W - $bits(t_result))'(0), r_o_res};

    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e_fire |=> r_o_vld)
        else $error("executed event produced no result");

    a_accept_fills_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_e_vld)
        else $error("accepted event lost");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_e_vld |-> !wr_en)
        else $error("slice write without an event");

endmodule

// ----- verif/round_robin_quantum_scheduler_core_tb.sv -----
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_core_tb
// Self-checking bench for the round-robin quantum scheduler. Events go in on
// the slave stream and results are taken from the master stream, both with
// random idle bursts. A scoreboard keeps its own copy of the scheduler state
// and checks every result field by field, in order. The run starts with a
// short directed sequence, then goes through several register settings with
// random ticks, switch requests and trap exits.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler_core_tb;
    import rrqs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_GUESTS = 16;
    localparam int unsigned RES_W      = $bits(t_result);
    localparam int unsigned PHASES     = 10;
    localparam int unsigned PHASE_LEN  = 200;

    class sched_scoreboard;
        t_cfg              regs;
        logic [ID_W-1:0]   run_id;
        logic              run_ok;
        logic [ID_W-1:0]   wait_id;
        logic              wait_ok;
        logic              lock_flag;
        logic [SLICE_W-1:0] slice_cnt [NUM_GUESTS];
        t_result           expected_q [$];
        int                errors;

        function new();
            regs.first_guest   = FIRST_GUEST_RST;
            regs.last_guest    = LAST_GUEST_RST;
            regs.quantum       = QUANTUM_RST;
            regs.manual_enable = 1'b0;
            regs.manual_guest  = '0;
            run_id    = '0;
            run_ok    = 1'b0;
            wait_id   = '0;
            wait_ok   = 1'b0;
            lock_flag = 1'b0;
            foreach (slice_cnt[g]) slice_cnt[g] = '0;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_FIRST_GUEST:   regs.first_guest   = val[ID_W-1:0];
                CFG_LAST_GUEST:    regs.last_guest    = val[ID_W-1:0];
                CFG_QUANTUM:       regs.quantum       = val[SLICE_W-1:0];
                CFG_MANUAL_ENABLE: regs.manual_enable = val[0];
                CFG_MANUAL_GUEST:  regs.manual_guest  = val[ID_W-1:0];
                default: ;
            endcase
        endfunction

        // Next guest on a timer tick; counts the running slice down.
        function logic [ID_W-1:0] next_on_tick();
            logic [ID_W-1:0] nxt;
            if (regs.manual_enable) return regs.manual_guest;
            if (!run_ok) return regs.first_guest;
            if (slice_cnt[run_id] > 1) begin
                slice_cnt[run_id] = slice_cnt[run_id] - 1'b1;
                return run_id;
            end
            slice_cnt[run_id] = '0;
            nxt = (run_id < regs.last_guest) ? run_id + 1'b1 : regs.first_guest;
            if (nxt == run_id) slice_cnt[run_id] = regs.quantum;
            return nxt;
        endfunction

        function logic try_set_pending(logic [ID_W-1:0] id);
            if (lock_flag) return 1'b0;
            wait_id = id;
            wait_ok = 1'b1;
            return 1'b1;
        endfunction

        function void note_event(t_item it);
            t_result r;
            r = '0;
            r.status = 1'b1;
            case (it.opcode)
                OP_TICK: begin
                    if (try_set_pending(next_on_tick())) r.status = 1'b0;
                end
                OP_SWITCH: begin
                    if (try_set_pending(it.target_guest)) r.status = 1'b0;
                    if (it.lock_after) lock_flag = 1'b1;
                end
                OP_TRAP: begin
                    if (!run_ok) begin
                        if (wait_ok) begin
                            slice_cnt[wait_id] = regs.quantum;
                            run_id     = wait_id;
                            run_ok     = 1'b1;
                            r.switched = 1'b1;
                            r.status   = 1'b0;
                        end
                    end else if (wait_ok && wait_id != run_id) begin
                        slice_cnt[wait_id] = regs.quantum;
                        r.previous_guest = run_id;
                        r.previous_valid = 1'b1;
                        run_id     = wait_id;
                        wait_ok    = 1'b0;
                        r.switched = 1'b1;
                        r.status   = 1'b0;
                    end
                    lock_flag = 1'b0;
                end
                default: ;
            endcase
            r.current_guest = run_ok ? run_id : '0;
            r.current_valid = run_ok;
            r.pending_guest = wait_ok ? wait_id : '0;
            r.pending_valid = wait_ok;
            r.locked        = lock_flag;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (errors < 50) $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        task cmp_field(string name, int got, int exp);
            if (got != exp) report_mismatch($sformatf("%s got %0d exp %0d", name, got, exp));
        endtask

        task check_result(logic [OUT_W-1:0] data);
            t_result got, exp;
            got = t_result'(data[RES_W-1:0]);
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result 0x%06h with nothing expected", data));
                return;
            end
            exp = expected_q.pop_front();
            cmp_field("status", got.status, exp.status);
            cmp_field("switched", got.switched, exp.switched);
            cmp_field("previous_guest", got.previous_guest, exp.previous_guest);
            cmp_field("previous_valid", got.previous_valid, exp.previous_valid);
            cmp_field("current_guest", got.current_guest, exp.current_guest);
            cmp_field("current_valid", got.current_valid, exp.current_valid);
            cmp_field("pending_guest", got.pending_guest, exp.pending_guest);
            cmp_field("pending_valid", got.pending_valid, exp.pending_valid);
            cmp_field("locked", got.locked, exp.locked);
            cmp_field("padding", int'(data[OUT_W-1:RES_W]), 0);
        endtask
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [CIDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]  i_cfg_wdata   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;   // target_guest[3:0], lock_after[4]
    logic [1:0]        s_axis_tuser  = '0;   // opcode[1:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;         // status, switched, previous_guest,
                                             // previous_valid, current_guest,
                                             // current_valid, pending_guest,
                                             // pending_valid, locked

    sched_scoreboard sb = new();
    bit              idle_on = 1'b1;
    int              sink_hold = 0;

    round_robin_quantum_scheduler_core #(
        .SLOT_COUNT(NUM_GUESTS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Result sink with random stall bursts.
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_hold     <= $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Transfer monitors on both streams.
    always @(posedge i_clk) begin
        t_item it;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            it.opcode       = t_opcode'(s_axis_tuser);
            it.target_guest = s_axis_tdata[ID_W-1:0];
            it.lock_after   = s_axis_tdata[ID_W];
            sb.note_event(it);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_item mk_item(t_opcode op, int tgt, bit lk);
        t_item it;
        it.opcode       = op;
        it.target_guest = tgt[ID_W-1:0];
        it.lock_after   = lk;
        return it;
    endfunction

    function automatic t_item rand_item();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return mk_item(OP_TICK, $urandom_range(0, 15), 1'($urandom_range(0, 1)));
        if (pick < 72) return mk_item(OP_TRAP, $urandom_range(0, 15), 1'($urandom_range(0, 1)));
        if (pick < 95) return mk_item(OP_SWITCH, $urandom_range(0, 15), $urandom_range(0, 3) == 0);
        return mk_item(OP_NONE, $urandom_range(0, 15), 1'($urandom_range(0, 1)));
    endfunction

    task automatic send_event(t_item it);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W-ID_W-1){1'b0}}, it.lock_after, it.target_guest};
        s_axis_tuser  <= it.opcode;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain(int max_cycles);
        int n;
        s_axis_tvalid <= 1'b0;
        n = 0;
        while (sb.expected_q.size() != 0 && n < max_cycles) begin
            @(posedge i_clk);
            n++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic apply_settings(t_cfg c);
        write_reg(CFG_FIRST_GUEST, CFG_W'(c.first_guest));
        write_reg(CFG_LAST_GUEST, CFG_W'(c.last_guest));
        write_reg(CFG_QUANTUM, c.quantum);
        write_reg(CFG_MANUAL_ENABLE, CFG_W'(c.manual_enable));
        write_reg(CFG_MANUAL_GUEST, CFG_W'(c.manual_guest));
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        t_item directed [$];
        t_cfg  c;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: guests 0..3, quantum 5.
        directed.push_back(mk_item(OP_TRAP, 0, 1'b0));     // launch with nothing pending
        directed.push_back(mk_item(OP_NONE, 15, 1'b1));    // unused opcode
        directed.push_back(mk_item(OP_TICK, 0, 1'b0));     // no guest: first guest pending
        directed.push_back(mk_item(OP_TRAP, 0, 1'b0));     // first launch, pending kept
        directed.push_back(mk_item(OP_TRAP, 0, 1'b0));     // pending equals running
        repeat (5) directed.push_back(mk_item(OP_TICK, 0, 1'b0)); // slice runs out
        directed.push_back(mk_item(OP_TICK, 0, 1'b0));     // slice already zero
        directed.push_back(mk_item(OP_SWITCH, 15, 1'b1));  // request and lock
        directed.push_back(mk_item(OP_SWITCH, 2, 1'b0));   // ignored while locked
        directed.push_back(mk_item(OP_TICK, 0, 1'b0));     // ignored while locked
        directed.push_back(mk_item(OP_TRAP, 0, 1'b0));     // switch to 15, unlock
        repeat (5) directed.push_back(mk_item(OP_TICK, 0, 1'b0)); // id above last wraps
        directed.push_back(mk_item(OP_SWITCH, 0, 1'b0));
        directed.push_back(mk_item(OP_SWITCH, 10, 1'b1));
        directed.push_back(mk_item(OP_TRAP, 15, 1'b1));
        foreach (directed[k]) send_event(directed[k]);

        for (int p = 0; p < PHASES; p++) begin
            drain(2000);
            case (p)
                0: c = '{first_guest: 0, last_guest: 15, quantum: 1,
                         manual_enable: 0, manual_guest: 0};
                1: c = '{first_guest: 15, last_guest: 15, quantum: 255,
                         manual_enable: 0, manual_guest: 15};
                2: c = '{first_guest: 9, last_guest: 9, quantum: 2,
                         manual_enable: 0, manual_guest: 0};
                3: c = '{first_guest: 15, last_guest: 0, quantum: 3,
                         manual_enable: 0, manual_guest: 0};
                4: c = '{first_guest: 0, last_guest: 7, quantum: 2,
                         manual_enable: 1, manual_guest: 15};
                5: c = '{first_guest: 2, last_guest: 5, quantum: 1,
                         manual_enable: 1, manual_guest: 0};
                default: begin
                    c.first_guest   = ID_W'($urandom_range(0, 15));
                    c.last_guest    = ID_W'($urandom_range(0, 15));
                    c.quantum       = ($urandom_range(0, 4) == 0) ?
                                      SLICE_W'($urandom_range(1, 255)) :
                                      SLICE_W'($urandom_range(1, 6));
                    c.manual_enable = ($urandom_range(0, 4) == 0);
                    c.manual_guest  = ID_W'($urandom_range(0, 15));
                end
            endcase
            apply_settings(c);
            idle_on = (p == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            repeat (PHASE_LEN) send_event(rand_item());
        end

        drain(20000);
        if (sb.expected_q.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rrqs_pkg.sv
hdl/rrqs_slice_mem.sv
hdl/rrqs_sched_ctrl.sv
hdl/round_robin_quantum_scheduler_core.sv
verif/round_robin_quantum_scheduler_core_tb.sv
